// ----- rtl/core/fifo_handle_pool_allocator_macros.svh -----
// assertion macros for the handle pool allocator
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_MACROS_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define FHPA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("fhpa assertion failed");
`define FHPA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fhpa implication failed");
`define FHPA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fhpa next-cycle check failed");
`else
`define FHPA_ASSERT(lbl, prop)
`define FHPA_ASSERT_IMP(lbl, ante, cons)
`define FHPA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/fhpa_pkg.sv -----
package fhpa_pkg;

   localparam int POOL_SIZE  = 256;
   localparam int POOL_LIMIT = (POOL_SIZE < 256) ? POOL_SIZE : 256;
   localparam int HANDLE_W   = 8;
   localparam int IDX_W      = (POOL_LIMIT > 1) ? $clog2(POOL_LIMIT) : 1;
   localparam int CNT_W      = $clog2(POOL_LIMIT + 1);
   localparam int CMP_W      = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CNT_W:0]      sum_type;
   typedef logic [CMP_W-1:0]    cmp_type;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_TRY     = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
   localparam logic [1:0] ST_EMPTY       = 2'd2;
   localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      handle_type release_handle;
   } req_type;

   typedef struct packed {
      handle_type granted_handle;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       pop;
      logic       push;
      handle_type push_data;
   } ring_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_sts_type;

   typedef struct packed {
      logic    en;
      idx_type idx;
      logic    value;
   } bmp_wr_type;

endpackage

// ----- rtl/core/fhpa_bitmap.sv -----
module fhpa_bitmap (
   input  logic                 clock,
   input  logic                 rd_en,
   input  fhpa_pkg::idx_type    rd_idx,
   input  fhpa_pkg::bmp_wr_type wr,
   output logic                 rd_data
);

   logic mem [fhpa_pkg::POOL_LIMIT];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fhpa_ring.sv -----
`include "fifo_handle_pool_allocator_macros.svh"

module fhpa_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  fhpa_pkg::ring_ctl_type ctl,
   output fhpa_pkg::handle_type   rd_data,
   output fhpa_pkg::ring_sts_type sts
);

   fhpa_pkg::handle_type mem [fhpa_pkg::POOL_LIMIT];
   fhpa_pkg::handle_type rd_data_ff;
   fhpa_pkg::idx_type    head_ff, head_in;
   fhpa_pkg::cnt_type    count_ff, count_in;
   fhpa_pkg::sum_type    tail_sum;
   fhpa_pkg::idx_type    tail_idx;

   // tail = head + count, wrapped once at the pool limit
   always_comb begin
      tail_sum = fhpa_pkg::sum_type'(head_ff) + fhpa_pkg::sum_type'(count_ff);
      if (tail_sum >= fhpa_pkg::sum_type'(fhpa_pkg::POOL_LIMIT)) begin
         tail_idx = fhpa_pkg::idx_type'(tail_sum
                    - fhpa_pkg::sum_type'(fhpa_pkg::POOL_LIMIT));
      end else begin
         tail_idx = fhpa_pkg::idx_type'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         if (head_ff == fhpa_pkg::idx_type'(fhpa_pkg::POOL_LIMIT - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + fhpa_pkg::idx_type'(1);
         end
         count_in = count_ff - fhpa_pkg::cnt_type'(1);
      end else if (ctl.push) begin
         count_in = count_ff + fhpa_pkg::cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_idx] <= ctl.push_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rd_data   = rd_data_ff;
   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == fhpa_pkg::cnt_type'(fhpa_pkg::POOL_LIMIT));

   `FHPA_ASSERT_IMP(a_pop_not_empty, ctl.pop, !sts.empty)
   `FHPA_ASSERT_IMP(a_push_not_full, ctl.push, !sts.full)
   `FHPA_ASSERT(a_no_push_and_pop, !(ctl.push && ctl.pop))
   `FHPA_ASSERT(a_count_bound, count_ff <= fhpa_pkg::cnt_type'(fhpa_pkg::POOL_LIMIT))

endmodule

// ----- rtl/core/fifo_handle_pool_allocator.sv -----
// channel  dir  beat                                    handshake
// req      in   opcode, release_handle (req_type)       req_valid / req_ready
// rsp      out  granted_handle, status (rsp_type)       rsp_valid / rsp_ready
//
// one req at a time: the ring head and bitmap are read through registers, so
// the accept edge loads those read registers, and the execute stage then writes
// back and loads the rsp register; req_ready is low while the execute stage is full
// a stalled rsp register holds that stage; a new req is taken while rsp waits
// synchronous reset clears pointers and counts; bitmap entries at or above
// the fresh counter read as free, so no clearing pass is needed
`include "fifo_handle_pool_allocator_macros.svh"

module fifo_handle_pool_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fhpa_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fhpa_pkg::rsp_type rsp_payload
);

   logic                   busy_ff, busy_in;
   logic [1:0]             op_ff;
   fhpa_pkg::handle_type   rel_ff;
   fhpa_pkg::cnt_type      fresh_ff, fresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   fhpa_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   req_accept;
   logic                   exec_fire;
   logic                   bmp_rd_data;
   logic                   rel_in_use;
   fhpa_pkg::handle_type   ring_rd_data;
   fhpa_pkg::ring_ctl_type ring_ctl;
   fhpa_pkg::ring_sts_type ring_sts;
   fhpa_pkg::bmp_wr_type   bmp_wr;
   fhpa_pkg::rsp_type      res;

   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign exec_fire  = busy_ff && (!rsp_valid_ff || rsp_ready);

   fhpa_bitmap u_bitmap (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_idx  (req_payload.release_handle[fhpa_pkg::IDX_W-1:0]),
      .wr      (bmp_wr),
      .rd_data (bmp_rd_data)
   );

   fhpa_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .ctl     (ring_ctl),
      .rd_data (ring_rd_data),
      .sts     (ring_sts)
   );

   // entries at or above the fresh counter were never handed out
   assign rel_in_use = (fhpa_pkg::cmp_type'(rel_ff) < fhpa_pkg::cmp_type'(fresh_ff))
                       && bmp_rd_data;

   always_comb begin
      ring_ctl = '0;
      bmp_wr   = '0;
      fresh_in = fresh_ff;
      res      = '0;
      unique case (op_ff)
         fhpa_pkg::OP_ALLOC: begin
            if (!ring_sts.empty) begin
               res.granted_handle = ring_rd_data;
               ring_ctl.pop       = exec_fire;
               bmp_wr.en          = exec_fire;
               bmp_wr.idx         = ring_rd_data[fhpa_pkg::IDX_W-1:0];
               bmp_wr.value       = 1'b1;
            end else if (fresh_ff != fhpa_pkg::cnt_type'(fhpa_pkg::POOL_LIMIT)) begin
               res.granted_handle = fhpa_pkg::handle_type'(fresh_ff);
               bmp_wr.en          = exec_fire;
               bmp_wr.idx         = fresh_ff[fhpa_pkg::IDX_W-1:0];
               bmp_wr.value       = 1'b1;
               if (exec_fire) begin
                  fresh_in = fresh_ff + fhpa_pkg::cnt_type'(1);
               end
            end else begin
               res.status = fhpa_pkg::ST_EXHAUSTED;
            end
         end
         fhpa_pkg::OP_TRY: begin
            if (!ring_sts.empty) begin
               res.granted_handle = ring_rd_data;
               ring_ctl.pop       = exec_fire;
               bmp_wr.en          = exec_fire;
               bmp_wr.idx         = ring_rd_data[fhpa_pkg::IDX_W-1:0];
               bmp_wr.value       = 1'b1;
            end else begin
               res.status = fhpa_pkg::ST_EMPTY;
            end
         end
         fhpa_pkg::OP_RELEASE: begin
            if (!rel_in_use || ring_sts.full) begin
               res.status = fhpa_pkg::ST_BAD_RELEASE;
            end else begin
               ring_ctl.push      = exec_fire;
               ring_ctl.push_data = rel_ff;
               bmp_wr.en          = exec_fire;
               bmp_wr.idx         = rel_ff[fhpa_pkg::IDX_W-1:0];
               bmp_wr.value       = 1'b0;
            end
         end
         default: begin
            res = '0;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (exec_fire) begin
         busy_in = 1'b0;
      end
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_payload.opcode;
         rel_ff <= req_payload.release_handle;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FHPA_ASSERT_NXT(a_fire_loads_rsp, exec_fire, rsp_valid_ff)
   `FHPA_ASSERT_IMP(a_pop_only_alloc, ring_ctl.pop,
      (op_ff == fhpa_pkg::OP_ALLOC) || (op_ff == fhpa_pkg::OP_TRY))
   `FHPA_ASSERT_IMP(a_push_only_release, ring_ctl.push,
      (op_ff == fhpa_pkg::OP_RELEASE) && rel_in_use)
   `FHPA_ASSERT(a_fresh_bound, fresh_ff <= fhpa_pkg::cnt_type'(fhpa_pkg::POOL_LIMIT))

endmodule
